### rtl/rgbconv_pkg.sv
// ----------------------------------------------------------------------------
// rgbconv_pkg
// Shared types and constants of the RGB 3x3 convolution block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rgbconv_pkg;

	localparam int MAX_WIDTH = 1024;
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int WCNT_W    = $clog2(MAX_WIDTH + 1);

	localparam int IW_W      = 11;
	localparam int IH_W      = 13;
	localparam int LINE_W    = IH_W + 1;
	localparam int WX_W      = (IW_W > WCNT_W) ? IW_W : WCNT_W;

	localparam int CFG_W     = 24;
	localparam int CFG_IDX_W = 3;

	localparam int CH_W      = 8;
	localparam int PIX_W     = 3 * CH_W;
	localparam int PROD_W    = 2 * CH_W;
	localparam int RSUM_W    = PROD_W + 2;
	localparam int SUM_W     = PROD_W + 4;
	localparam int CH_MAX    = 255;

	typedef logic [PIX_W-1:0] pix_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH   = 3'd0,
		REG_IMAGE_HEIGHT  = 3'd1,
		REG_KERNEL_TOP    = 3'd2,
		REG_KERNEL_MID    = 3'd3,
		REG_KERNEL_BOTTOM = 3'd4
	} cfg_reg_t;

endpackage

`default_nettype wire

### rtl/rgb_convolution_3x3_clamped.sv
// ----------------------------------------------------------------------------
// rgb_convolution_3x3_clamped
// Streaming 3x3 signed convolution of RGB pixels with zero borders and
// clamping of each channel to 0..255.
//
// Pixels enter in raster order, top line first, one request per clock
// unless the output stalls; a drain request inside the frame's pixels is
// taken and ignored. A pixel's result leaves once image_width + 1 further
// requests have been taken, through the line store read, the product stage,
// the row sum stage and the output register. After the last pixel of a frame,
// image_width + 1 drain requests flush the remaining results; frame_end marks
// the last one. Each line store is read once and written once per request,
// which sets one request per clock unless the output stalls. The line stores
// are not cleared at reset; the block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgb_convolution_3x3_clamped
	import rgbconv_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,

	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,

	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic                 drain,
	input  wire logic [CH_W-1:0]      red_in,
	input  wire logic [CH_W-1:0]      green_in,
	input  wire logic [CH_W-1:0]      blue_in,

	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [CH_W-1:0]           red_out,
	output logic [CH_W-1:0]           green_out,
	output logic [CH_W-1:0]           blue_out,
	output logic                      frame_end
);

	function automatic logic signed [PROD_W-1:0] mul_px(
		input logic signed [CH_W-1:0] k,
		input logic [CH_W-1:0]        px
	);
		logic signed [2*CH_W:0] full;
		full = k * $signed({1'b0, px});
		return full[PROD_W-1:0];
	endfunction

	// configuration
	logic [IW_W-1:0]  width_q;
	logic [IH_W-1:0]  height_q;
	logic [CFG_W-1:0] krow_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= IW_W'(1);
			height_q <= IH_W'(1);
			for (int r = 0; r < 3; r++) krow_q[r] <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:   width_q   <= cfg_data[IW_W-1:0];
				REG_IMAGE_HEIGHT:  height_q  <= cfg_data[IH_W-1:0];
				REG_KERNEL_TOP:    krow_q[0] <= cfg_data;
				REG_KERNEL_MID:    krow_q[1] <= cfg_data;
				REG_KERNEL_BOTTOM: krow_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// handshake and stage control
	logic valid_s1, valid_s2, valid_s3, out_valid_q;
	logic res_s1;
	logic rdy_out, rdy3, rdy2;
	logic adv1, adv2, adv3;
	logic acc_in, acc_rd;

	// slot position
	logic [COL_W-1:0]  col_q, col_nx, xi;
	logic [LINE_W-1:0] line_q, line_nx, yi, yc, h_ln;
	logic [WX_W-1:0]   iw_x;
	logic [WCNT_W-1:0] w_eff, xi_p1;
	logic [IH_W-1:0]   h_eff;
	logic restart, in_frame, drop, res_d, fend_d;
	logic mask_l_d, mask_r_d, mask_t_d, mask_b_d;
	pix_t pix_d;

	always_comb begin
		iw_x = WX_W'(width_q);
		if (iw_x == '0) begin
			w_eff = WCNT_W'(1);
		end else if (iw_x > WX_W'(MAX_WIDTH)) begin
			w_eff = WCNT_W'(MAX_WIDTH);
		end else begin
			w_eff = WCNT_W'(iw_x);
		end
		h_eff = (height_q == '0) ? IH_W'(1) : height_q;
		h_ln  = LINE_W'(h_eff);

		restart = (WCNT_W'(col_q) >= w_eff) || (line_q > h_ln + LINE_W'(1)) ||
			((line_q == h_ln + LINE_W'(1)) && (col_q != '0));
		xi = restart ? '0 : col_q;
		yi = restart ? '0 : line_q;

		in_frame = yi < h_ln;
		drop     = in_frame && drain;
		pix_d    = in_frame ? {red_in, green_in, blue_in} : '0;
		res_d    = (yi >= LINE_W'(2)) || ((yi == LINE_W'(1)) && (xi != '0));

		// center of the window lags one line and one column behind the slot
		yc       = yi - ((xi == '0) ? LINE_W'(2) : LINE_W'(1));
		mask_l_d = (xi == '0) ? (w_eff == WCNT_W'(1)) : (xi == COL_W'(1));
		mask_r_d = (xi == '0);
		mask_t_d = (yc == '0);
		mask_b_d = (yc == h_ln - LINE_W'(1));
		fend_d   = res_d && mask_b_d && mask_r_d;

		xi_p1 = WCNT_W'(xi) + WCNT_W'(1);
		if (drop) begin
			col_nx  = xi;
			line_nx = yi;
		end else if (fend_d) begin
			col_nx  = '0;
			line_nx = '0;
		end else if (xi_p1 == w_eff) begin
			col_nx  = '0;
			line_nx = yi + LINE_W'(1);
		end else begin
			col_nx  = xi_p1[COL_W-1:0];
			line_nx = yi;
		end
	end

	assign rdy_out  = !out_valid_q || out_ready;
	assign rdy3     = !valid_s3 || rdy_out;
	assign adv3     = valid_s3 && rdy_out;
	assign rdy2     = !valid_s2 || rdy3;
	assign adv2     = valid_s2 && rdy3;
	assign adv1     = valid_s1 && (rdy2 || !res_s1);
	assign in_ready = !valid_s1 || adv1;
	assign acc_in   = in_valid && in_ready;
	assign acc_rd   = acc_in && !drop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			line_q <= '0;
		end else if (acc_in) begin
			col_q  <= col_nx;
			line_q <= line_nx;
		end
	end

	// stage 1: line store read
	logic [COL_W-1:0] xi_s1;
	pix_t pix_s1;
	logic fend_s1, mask_l_s1, mask_r_s1, mask_t_s1, mask_b_s1;
	pix_t rd_upper_q, rd_lower_q;
	pix_t fwd_upper_q, fwd_lower_q;
	logic fwd_q;
	pix_t top_eff, mid_eff;
	pix_t upper_mem [MAX_WIDTH];
	pix_t lower_mem [MAX_WIDTH];

	assign top_eff = fwd_q ? fwd_upper_q : rd_upper_q;
	assign mid_eff = fwd_q ? fwd_lower_q : rd_lower_q;

	always_ff @(posedge clk) begin
		if (adv1) begin
			upper_mem[xi_s1] <= mid_eff;
			lower_mem[xi_s1] <= pix_s1;
		end
		if (acc_rd) begin
			rd_upper_q <= upper_mem[xi];
			rd_lower_q <= lower_mem[xi];
		end
	end

	// write of the item leaving stage 1 lands on the same edge as the read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (acc_rd) begin
			fwd_q <= valid_s1 && (xi_s1 == xi);
		end
	end

	always_ff @(posedge clk) begin
		if (acc_rd) begin
			fwd_upper_q <= mid_eff;
			fwd_lower_q <= pix_s1;
			xi_s1       <= xi;
			pix_s1      <= pix_d;
			res_s1      <= res_d;
			fend_s1     <= fend_d;
			mask_l_s1   <= mask_l_d;
			mask_r_s1   <= mask_r_d;
			mask_t_s1   <= mask_t_d;
			mask_b_s1   <= mask_b_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc_in) begin
			valid_s1 <= !drop;
		end else if (adv1) begin
			valid_s1 <= 1'b0;
		end
	end

	// window: two older columns, the newest comes from the stores and the incoming pixel
	pix_t win_q [2][3];
	pix_t nwin [3][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < 2; c++)
				for (int r = 0; r < 3; r++) win_q[c][r] <= '0;
		end else if (adv1) begin
			for (int r = 0; r < 3; r++) begin
				win_q[0][r] <= win_q[1][r];
				win_q[1][r] <= nwin[2][r];
			end
		end
	end

	// stage 2: masked products
	logic signed [PROD_W-1:0] prod_d  [3][3][3];
	logic signed [PROD_W-1:0] prod_s2 [3][3][3];
	logic fend_s2;

	always_comb begin
		logic keep;
		keep = 1'b0;
		for (int r = 0; r < 3; r++) begin
			nwin[0][r] = win_q[0][r];
			nwin[1][r] = win_q[1][r];
		end
		nwin[2][0] = top_eff;
		nwin[2][1] = mid_eff;
		nwin[2][2] = pix_s1;
		for (int ch = 0; ch < 3; ch++) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					keep = !((c == 0 && mask_l_s1) || (c == 2 && mask_r_s1) ||
						(r == 0 && mask_t_s1) || (r == 2 && mask_b_s1));
					prod_d[ch][r][c] = keep ?
						mul_px(krow_q[r][CH_W*c +: CH_W], nwin[c][r][CH_W*(2-ch) +: CH_W]) :
						'0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && res_s1) begin
			prod_s2 <= prod_d;
			fend_s2 <= fend_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv1 && res_s1) begin
			valid_s2 <= 1'b1;
		end else if (adv2) begin
			valid_s2 <= 1'b0;
		end
	end

	// stage 3: row sums
	logic signed [RSUM_W-1:0] rsum_d  [3][3];
	logic signed [RSUM_W-1:0] rsum_s3 [3][3];
	logic fend_s3;

	always_comb begin
		for (int ch = 0; ch < 3; ch++)
			for (int r = 0; r < 3; r++)
				rsum_d[ch][r] = RSUM_W'(prod_s2[ch][r][0]) + RSUM_W'(prod_s2[ch][r][1]) +
					RSUM_W'(prod_s2[ch][r][2]);
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			rsum_s3 <= rsum_d;
			fend_s3 <= fend_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv2) begin
			valid_s3 <= 1'b1;
		end else if (adv3) begin
			valid_s3 <= 1'b0;
		end
	end

	// output register: total and clamp
	logic signed [SUM_W-1:0] tot [3];
	logic [CH_W-1:0] clamp_d [3];
	logic [CH_W-1:0] red_q, green_q, blue_q;
	logic fend_q;

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			tot[ch] = SUM_W'(rsum_s3[ch][0]) + SUM_W'(rsum_s3[ch][1]) +
				SUM_W'(rsum_s3[ch][2]);
			if (tot[ch][SUM_W-1]) begin
				clamp_d[ch] = '0;
			end else if (tot[ch] > $signed(SUM_W'(CH_MAX))) begin
				clamp_d[ch] = CH_W'(CH_MAX);
			end else begin
				clamp_d[ch] = tot[ch][CH_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			red_q   <= clamp_d[0];
			green_q <= clamp_d[1];
			blue_q  <= clamp_d[2];
			fend_q  <= fend_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv3) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign red_out   = red_q;
	assign green_out = green_q;
	assign blue_out  = blue_q;
	assign frame_end = fend_q;

`ifndef SYNTHESIS
	a_fwd_pairing: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_in && valid_s1) |-> adv1)
		else $error("request taken while stage 1 holds without write-back");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		acc_in |=> (WCNT_W'(col_q) < $past(w_eff)))
		else $error("column counter beyond line width");

	a_line_range: assert property (@(posedge clk) disable iff (!arst_n)
		acc_in |=> (line_q <= $past(h_ln) + LINE_W'(1)))
		else $error("line counter beyond flush lines");
`endif

endmodule

`default_nettype wire

### test/rgbconv_checker.sv
// ----------------------------------------------------------------------------
// rgbconv_checker
// Watches the configuration port and both request channels of the RGB 3x3
// convolution block. Keeps its own copy of the registers, line stores,
// window and frame position, works out the filtered pixel that each accepted
// request leads to, and compares every accepted result with the oldest
// outstanding one. Reports the failure count and the number of outstanding
// results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgbconv_checker
	import rgbconv_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,

	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,

	input  wire logic                 in_valid,
	input  wire logic                 in_ready,
	input  wire logic                 drain,
	input  wire logic [CH_W-1:0]      red_in,
	input  wire logic [CH_W-1:0]      green_in,
	input  wire logic [CH_W-1:0]      blue_in,

	input  wire logic                 out_valid,
	input  wire logic                 out_ready,
	input  wire logic [CH_W-1:0]      red_out,
	input  wire logic [CH_W-1:0]      green_out,
	input  wire logic [CH_W-1:0]      blue_out,
	input  wire logic                 frame_end,

	output int                        errors,
	output int                        pending
);

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic            last;
	} filtered_pixel_t;

	logic [IW_W-1:0]  width_cfg;
	logic [IH_W-1:0]  height_cfg;
	logic [CFG_W-1:0] kernel_rows [3];

	// line two back and line one back, by column
	pix_t             line_above [MAX_WIDTH];
	pix_t             line_prev  [MAX_WIDTH];
	// [column * 3 + row], column 0 = left, row 0 = top
	pix_t             window [9];
	int unsigned      column_pos;
	int unsigned      line_pos;

	filtered_pixel_t  expected_pixels [$];

	function automatic logic [CH_W-1:0] saturate(input int v);
		if (v < 0)
			return '0;
		if (v > CH_MAX)
			return CH_W'(CH_MAX);
		return CH_W'(v);
	endfunction

	task automatic move_to_next_slot(input int unsigned xi, input int unsigned yi,
			input int unsigned w);
		column_pos = xi + 1;
		if (column_pos == w) begin
			column_pos = 0;
			line_pos   = yi + 1;
		end
	endtask

	task automatic filter_request(input logic is_drain, input pix_t px);
		int unsigned     w;
		int unsigned     h;
		int unsigned     xi;
		int unsigned     yi;
		int unsigned     xc;
		int unsigned     yc;
		int              acc [3];
		int              coeff;
		pix_t            incoming;
		pix_t            nb;
		logic            at_left;
		logic            at_right;
		logic            at_top;
		logic            at_bottom;
		filtered_pixel_t res;

		w = width_cfg;
		h = height_cfg;
		if (w == 0)
			w = 1;
		if (w > MAX_WIDTH)
			w = MAX_WIDTH;
		if (h == 0)
			h = 1;

		// position beyond the current frame: restart the frame
		if (column_pos >= w || line_pos > h + 1 || (line_pos == h + 1 && column_pos != 0)) begin
			column_pos = 0;
			line_pos   = 0;
		end
		xi = column_pos;
		yi = line_pos;

		if (yi < h) begin
			if (is_drain)
				return;
			incoming = px;
		end else begin
			incoming = '0;
		end

		for (int i = 0; i < 6; i++)
			window[i] = window[i + 3];
		window[6]      = line_above[xi];
		window[7]      = line_prev[xi];
		window[8]      = incoming;
		line_above[xi] = line_prev[xi];
		line_prev[xi]  = incoming;

		if (yi == 0 || (yi == 1 && xi == 0)) begin
			move_to_next_slot(xi, yi, w);
			return;
		end

		if (xi == 0) begin
			xc = w - 1;
			yc = yi - 2;
		end else begin
			xc = xi - 1;
			yc = yi - 1;
		end
		at_left   = (xc == 0);
		at_right  = (xc == w - 1);
		at_top    = (yc == 0);
		at_bottom = (yc == h - 1);

		acc = '{0, 0, 0};
		for (int c = 0; c < 3; c++) begin
			if ((c == 0 && at_left) || (c == 2 && at_right))
				continue;
			for (int r = 0; r < 3; r++) begin
				if ((r == 0 && at_top) || (r == 2 && at_bottom))
					continue;
				nb    = window[c * 3 + r];
				coeff = $signed(kernel_rows[r][8 * c +: 8]);
				for (int ch = 0; ch < 3; ch++)
					acc[ch] += coeff * int'(nb[16 - 8 * ch +: 8]);
			end
		end

		res.red   = saturate(acc[0]);
		res.green = saturate(acc[1]);
		res.blue  = saturate(acc[2]);
		res.last  = at_bottom && at_right;
		expected_pixels.push_back(res);

		if (res.last) begin
			column_pos = 0;
			line_pos   = 0;
		end else begin
			move_to_next_slot(xi, yi, w);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		filtered_pixel_t exp_px;

		if (!arst_n) begin
			width_cfg  = 1;
			height_cfg = 1;
			for (int r = 0; r < 3; r++)
				kernel_rows[r] = '0;
			for (int i = 0; i < 9; i++)
				window[i] = '0;
			column_pos = 0;
			line_pos   = 0;
			expected_pixels.delete();
			errors     = 0;
			pending    = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_pixels.size() == 0) begin
					$display("%0t: unexpected result r=%0d g=%0d b=%0d frame_end=%0b",
						$time, red_out, green_out, blue_out, frame_end);
					errors++;
				end else begin
					exp_px = expected_pixels.pop_front();
					if (red_out !== exp_px.red || green_out !== exp_px.green ||
							blue_out !== exp_px.blue || frame_end !== exp_px.last) begin
						$display("%0t: result mismatch, expected r=%0d g=%0d b=%0d frame_end=%0b, got r=%0d g=%0d b=%0d frame_end=%0b",
							$time, exp_px.red, exp_px.green, exp_px.blue, exp_px.last,
							red_out, green_out, blue_out, frame_end);
						errors++;
					end
				end
			end

			if (cfg_we) begin
				case (cfg_index)
					REG_IMAGE_WIDTH:   width_cfg      = cfg_data[IW_W-1:0];
					REG_IMAGE_HEIGHT:  height_cfg     = cfg_data[IH_W-1:0];
					REG_KERNEL_TOP:    kernel_rows[0] = cfg_data;
					REG_KERNEL_MID:    kernel_rows[1] = cfg_data;
					REG_KERNEL_BOTTOM: kernel_rows[2] = cfg_data;
					default: ;
				endcase
			end

			if (in_valid && in_ready)
				filter_request(drain, {red_in, green_in, blue_in});

			pending = expected_pixels.size();
		end
	end

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the RGB 3x3 convolution block. A short directed
// run covers extreme pixels and coefficients, ignored drains, pixels in the
// flush, mid-frame register changes and out-of-range registers. Random small
// frames follow, plus a wide frame sent with no gaps and a tall narrow frame,
// with random gaps on both channels, a long output stall and pauses between
// phases. Checking is done by rgbconv_checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
	import rgbconv_pkg::*;

	localparam int IDLE_LIMIT   = 5000;
	localparam int STALL_CYCLES = 400;
	localparam int SETTLE_WAIT  = 8;
	localparam int SMALL_ITEMS  = 900;
	localparam int WIDE_FRAME   = 40;
	localparam int TALL_FRAME   = 60;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic                 drain;
	logic [CH_W-1:0]      red_in;
	logic [CH_W-1:0]      green_in;
	logic [CH_W-1:0]      blue_in;
	logic                 out_valid;
	logic                 out_ready;
	logic [CH_W-1:0]      red_out;
	logic [CH_W-1:0]      green_out;
	logic [CH_W-1:0]      blue_out;
	logic                 frame_end;

	int                   failures;
	int                   pending_pixels;

	bit                   steady;
	int                   stall_asked;
	int                   stall_served;
	int                   idle_cycles;
	int                   requests;
	int                   frames;
	int                   small_items;
	int                   widest;
	int                   tallest;

	always #5 clk = ~clk;

	rgb_convolution_3x3_clamped DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.drain     (drain),
		.red_in    (red_in),
		.green_in  (green_in),
		.blue_in   (blue_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.red_out   (red_out),
		.green_out (green_out),
		.blue_out  (blue_out),
		.frame_end (frame_end)
	);

	rgbconv_checker result_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.drain     (drain),
		.red_in    (red_in),
		.green_in  (green_in),
		.blue_in   (blue_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.red_out   (red_out),
		.green_out (green_out),
		.blue_out  (blue_out),
		.frame_end (frame_end),
		.errors    (failures),
		.pending   (pending_pixels)
	);

	function automatic logic [CH_W-1:0] pick_channel();
		case ($urandom_range(3))
			0:       return '0;
			1:       return CH_W'(CH_MAX);
			default: return CH_W'($urandom);
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] random_kernel_row();
		logic [CFG_W-1:0] k;

		k = '0;
		case ($urandom_range(3))
			0: k = CFG_W'($urandom);
			1: for (int i = 0; i < 3; i++)
				k[8 * i +: 8] = 8'($urandom_range(6) + 253);  // -3..3
			2: k[8 * $urandom_range(2) +: 8] = 8'd1;
			default: for (int i = 0; i < 3; i++)
				case ($urandom_range(3))
					0:       k[8 * i +: 8] = 8'h80;
					1:       k[8 * i +: 8] = 8'h7F;
					2:       k[8 * i +: 8] = 8'hFF;
					default: k[8 * i +: 8] = 8'h00;
				endcase
		endcase
		return k;
	endfunction

	// all tasks start and end at a falling edge
	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_we    = 1'b0;
	endtask

	task automatic configure(input int w, input int h, input logic [CFG_W-1:0] k_top,
			input logic [CFG_W-1:0] k_mid, input logic [CFG_W-1:0] k_bot);
		write_reg(REG_IMAGE_WIDTH, CFG_W'(w));
		write_reg(REG_IMAGE_HEIGHT, CFG_W'(h));
		write_reg(REG_KERNEL_TOP, k_top);
		write_reg(REG_KERNEL_MID, k_mid);
		write_reg(REG_KERNEL_BOTTOM, k_bot);
		if (w > widest)
			widest = w;
		if (h > tallest)
			tallest = h;
	endtask

	task automatic settle();
		in_valid = 1'b0;
		while (pending_pixels != 0)
			@(negedge clk);
		repeat (SETTLE_WAIT) @(negedge clk);
	endtask

	task automatic offer(input logic d, input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
			input logic [CH_W-1:0] b);
		if (!steady) begin
			while ($urandom_range(99) < 13) begin
				in_valid = 1'b0;
				@(negedge clk);
			end
		end
		in_valid = 1'b1;
		drain    = d;
		red_in   = r;
		green_in = g;
		blue_in  = b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		requests++;
		@(negedge clk);
	endtask

	task automatic send_pixel();
		offer(1'b0, pick_channel(), pick_channel(), pick_channel());
	endtask

	task automatic send_drain();
		offer(1'b1, pick_channel(), pick_channel(), pick_channel());
	endtask

	task automatic send_frame(input int w, input int h, input bit noisy, input bit may_abort,
			output bit aborted);
		int stop_at;

		stop_at = w * h;
		if (may_abort && $urandom_range(9) == 0)
			stop_at = $urandom_range(w * h - 1);
		for (int n = 0; n < stop_at; n++) begin
			if (noisy && $urandom_range(19) == 0)
				send_drain();  // ignored inside the frame
			send_pixel();
		end
		small_items += stop_at;
		aborted = (stop_at < w * h);
		if (aborted)
			return;
		for (int i = 0; i <= w; i++) begin
			if (noisy && $urandom_range(6) == 0)
				send_pixel();  // taken as a drain in the flush
			else
				send_drain();
		end
		small_items += w + 1;
		if (noisy && $urandom_range(4) == 0)
			repeat ($urandom_range(1, 3)) send_drain();
		frames++;
	endtask

	// result side: random back-pressure plus one long hold-off on request
	initial begin
		out_ready    = 1'b0;
		stall_served = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (stall_asked != stall_served) begin
				stall_served++;
				out_ready = 1'b0;
				repeat (STALL_CYCLES - 1) @(negedge clk);
			end else begin
				out_ready = steady || ($urandom_range(99) >= 13);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || cfg_we || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no request moved for %0d cycles", $time, IDLE_LIMIT);
			$display("FAIL rgb_convolution_3x3_clamped");
			$finish;
		end
	end

	initial begin
		int w_reg;
		int h_reg;
		int w_eff;
		int h_eff;
		int nframes;
		bit aborted;

		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = REG_IMAGE_WIDTH;
		cfg_data    = '0;
		in_valid    = 1'b0;
		drain       = 1'b0;
		red_in      = '0;
		green_in    = '0;
		blue_in     = '0;
		steady      = 1'b0;
		stall_asked = 0;
		requests    = 0;
		frames      = 0;
		small_items = 0;
		widest      = 0;
		tallest     = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// extreme coefficients, ignored drain, pixel in the flush, extra drains
		configure(3, 2, 24'h80_7F_01, 24'h00_01_00, 24'hFF_FF_FF);
		offer(1'b1, 8'hFF, 8'hFF, 8'hFF);
		offer(1'b0, 8'hFF, 8'hFF, 8'hFF);
		offer(1'b0, 8'h00, 8'h00, 8'h00);
		offer(1'b0, 8'hFF, 8'h00, 8'h80);
		offer(1'b0, 8'h01, 8'h02, 8'h03);
		offer(1'b0, 8'h00, 8'hFF, 8'h00);
		offer(1'b0, 8'h80, 8'h7F, 8'h55);
		offer(1'b1, 8'h00, 8'h00, 8'h00);
		offer(1'b0, 8'hC8, 8'h64, 8'h32);
		offer(1'b1, 8'hAA, 8'h55, 8'hAA);
		offer(1'b1, 8'h00, 8'h00, 8'h00);
		offer(1'b1, 8'h00, 8'h00, 8'h00);
		offer(1'b1, 8'hFF, 8'hFF, 8'hFF);
		settle();

		// frame cut short, then a narrower width forces a restart
		configure(4, 3, 24'h01_01_01, 24'h01_FF_01, 24'h00_02_00);
		repeat (6) send_pixel();
		settle();
		write_reg(REG_IMAGE_WIDTH, CFG_W'(2));
		write_reg(REG_IMAGE_HEIGHT, CFG_W'(1));
		send_frame(2, 1, 1'b0, 1'b0, aborted);
		settle();

		// zero width and height count as one
		configure(0, 0, 24'h00_00_00, 24'h00_03_00, 24'h00_00_00);
		send_frame(1, 1, 1'b0, 1'b0, aborted);

		for (int phase = 0; phase < 3 || small_items < SMALL_ITEMS; phase++) begin
			settle();
			case (phase)
				0: begin
					// also fills every column that the random frames can reach
					steady = 1'b1;
					configure(WIDE_FRAME, 2, random_kernel_row(), random_kernel_row(),
						random_kernel_row());
					send_frame(WIDE_FRAME, 2, 1'b0, 1'b0, aborted);
				end
				1: begin
					configure(WIDE_FRAME, 2, random_kernel_row(), random_kernel_row(),
						random_kernel_row());
					stall_asked++;
					send_frame(WIDE_FRAME, 2, 1'b1, 1'b0, aborted);
				end
				2: begin
					configure(1, TALL_FRAME, random_kernel_row(), random_kernel_row(),
						random_kernel_row());
					send_frame(1, TALL_FRAME, 1'b1, 1'b0, aborted);
				end
				default: begin
					case ($urandom_range(12))
						0:       w_reg = 0;
						1:       w_reg = $urandom_range(9, WIDE_FRAME);
						default: w_reg = $urandom_range(1, 8);
					endcase
					h_reg = ($urandom_range(12) == 0) ? 0 : $urandom_range(1, 6);
					w_eff = (w_reg == 0) ? 1 : w_reg;
					h_eff = (h_reg == 0) ? 1 : h_reg;
					configure(w_reg, h_reg, random_kernel_row(), random_kernel_row(),
						random_kernel_row());
					nframes = $urandom_range(1, 3);
					for (int f = 0; f < nframes; f++) begin
						send_frame(w_eff, h_eff, 1'b1, 1'b1, aborted);
						if (aborted)
							break;
					end
				end
			endcase
			steady = 1'b0;
		end

		settle();
		repeat (20) @(negedge clk);

		$display("Run covered %0d complete frames in %0d requests, widths up to %0d, heights up to %0d,",
			frames, requests, widest, tallest);
		$display("with ignored drains, pixels in the flush, restarts and a long output stall.");
		if (failures == 0)
			$display("PASS rgb_convolution_3x3_clamped");
		else
			$display("FAIL rgb_convolution_3x3_clamped");
		$finish;
	end

endmodule
